/* src/lcp_pkg.sv */
// Line command parser package: line state struct, response codes, keyword text.
// No dependencies; imported by lcp_step and line_command_parser.
`default_nettype none
package lcp_pkg;

    localparam int LINE_CAPACITY = 64;
    localparam int LEN_W         = $clog2(LINE_CAPACITY);

    localparam int NUM_W     = 18;
    localparam int TIME_W    = 17;
    localparam int PROD_W    = NUM_W + 4;

    localparam logic [NUM_W-1:0]  NUMBER_CAP   = NUM_W'(262143);
    localparam logic [NUM_W-1:0]  TIME_MIN     = NUM_W'(10);
    localparam logic [NUM_W-1:0]  TIME_MAX     = NUM_W'(100000);
    localparam logic [TIME_W-1:0] TIME_DEFAULT = TIME_W'(20);

    localparam logic [LEN_W-1:0] LEN_START  = LEN_W'(5);
    localparam logic [LEN_W-1:0] LEN_STOP   = LEN_W'(4);
    localparam logic [LEN_W-1:0] LEN_STATUS = LEN_W'(6);
    localparam logic [LEN_W-1:0] LEN_PREFIX = LEN_W'(13);
    localparam logic [LEN_W-1:0] LEN_LAST   = LEN_W'(LINE_CAPACITY - 1);

    // candidate bits
    localparam int KW_START  = 0;
    localparam int KW_STOP   = 1;
    localparam int KW_STATUS = 2;
    localparam int KW_PREFIX = 3;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        RSP_STARTED  = 3'd0,
        RSP_STOPPED  = 3'd1,
        RSP_STATUS   = 3'd2,
        RSP_TIME_SET = 3'd3,
        RSP_INVALID  = 3'd4,
        RSP_UNKNOWN  = 3'd5,
        RSP_TOO_LONG = 3'd6
    } rsp_code_t;

    typedef enum logic [1:0] {
        NUM_LEAD   = 2'd0,
        NUM_DIGITS = 2'd1,
        NUM_DONE   = 2'd2
    } num_phase_t;

    typedef struct packed {
        logic [LEN_W-1:0]  line_len;
        logic [LEN_W-1:0]  content_len;
        logic [3:0]        kw_cand;
        logic [LEN_W-1:0]  space_run;
        logic              nul_seen;
        num_phase_t        num_phase;
        logic              num_neg;
        logic [NUM_W-1:0]  num_val;
        logic              running;
        logic [TIME_W-1:0] stored_time;
    } lcp_state_t;

    typedef struct packed {
        logic              valid;
        rsp_code_t         code;
        logic              running;
        logic [TIME_W-1:0] itime;
    } lcp_result_t;

    localparam lcp_state_t STATE_RESET = '{
        line_len:    '0,
        content_len: '0,
        kw_cand:     4'hF,
        space_run:   '0,
        nul_seen:    1'b0,
        num_phase:   NUM_LEAD,
        num_neg:     1'b0,
        num_val:     '0,
        running:     1'b0,
        stored_time: TIME_DEFAULT
    };

    // keyword characters by position; NUL past the end never matches a live byte
    function automatic logic [7:0] start_char(input logic [LEN_W-1:0] p);
        logic [7:0] c;
        case (p)
            LEN_W'(0): c = "S";
            LEN_W'(1): c = "T";
            LEN_W'(2): c = "A";
            LEN_W'(3): c = "R";
            LEN_W'(4): c = "T";
            default:   c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] stop_char(input logic [LEN_W-1:0] p);
        logic [7:0] c;
        case (p)
            LEN_W'(0): c = "S";
            LEN_W'(1): c = "T";
            LEN_W'(2): c = "O";
            LEN_W'(3): c = "P";
            default:   c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] status_char(input logic [LEN_W-1:0] p);
        logic [7:0] c;
        case (p)
            LEN_W'(0): c = "S";
            LEN_W'(1): c = "T";
            LEN_W'(2): c = "A";
            LEN_W'(3): c = "T";
            LEN_W'(4): c = "U";
            LEN_W'(5): c = "S";
            default:   c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] prefix_char(input logic [LEN_W-1:0] p);
        logic [7:0] c;
        case (p)
            LEN_W'(0):  c = "S";
            LEN_W'(1):  c = "E";
            LEN_W'(2):  c = "T";
            LEN_W'(3):  c = "_";
            LEN_W'(4):  c = "I";
            LEN_W'(5):  c = "N";
            LEN_W'(6):  c = "T";
            LEN_W'(7):  c = "_";
            LEN_W'(8):  c = "T";
            LEN_W'(9):  c = "I";
            LEN_W'(10): c = "M";
            LEN_W'(11): c = "E";
            LEN_W'(12): c = ":";
            default:    c = CH_NUL;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

/* src/line_command_parser.sv */
// A byte is registered on accept, and its response, if any, is registered in the output
// register when that byte advances; m_tvalid rises as the output register loads.
// Throughput: one byte per cycle unless a response waits; lcp_step is combinational.
// A waiting response holds the state; the input register still takes one byte.
// Reset (aresetn low, synchronous): line state cleared, idle, integration time 20.
// Depends on lcp_pkg and lcp_step.
`default_nettype none
module line_command_parser (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // [2:0] response_code, [3] running,
                                        // [20:4] integration_time, [23:21] zero
);
    import lcp_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    lcp_state_t  st_reg;
    lcp_state_t  st_next;
    lcp_result_t res;
    logic        m_valid_reg;
    logic [23:0] m_data_reg;
    logic        out_free;
    logic        advance;

    lcp_step u_step (
        .rx_byte (byte_reg),
        .st      (st_reg),
        .st_next (st_next),
        .res     (res)
    );

    assign out_free = !m_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            st_reg       <= STATE_RESET;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
                byte_reg     <= s_tdata;
            end
            if (advance) begin
                st_reg <= st_next;
            end
            if (out_free) begin
                m_valid_reg <= advance && res.valid;
                m_data_reg  <= {3'b000, res.itime, res.running, res.code};
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.stored_time >= TIME_MIN[TIME_W-1:0] && st_reg.stored_time <= TIME_MAX[TIME_W-1:0])
        else $error("stored integration time out of range");

    a_len_order: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.line_len <= LEN_LAST && st_reg.content_len <= st_reg.line_len &&
        st_reg.space_run <= st_reg.content_len)
        else $error("line length bookkeeping inconsistent");

    a_start_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg[2:0] == RSP_STARTED |-> m_data_reg[3])
        else $error("start response without running flag");

    a_stop_idles: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg[2:0] == RSP_STOPPED |-> !m_data_reg[3])
        else $error("stop response with running flag");

    a_held_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_tready |=> st_reg == $past(st_reg) || !$past(in_valid_reg))
        else $error("state advanced while result stalled");

endmodule
`default_nettype wire

/* src/lcp_step.sv */
// One byte step of the parser: next line state and optional response.
// Combinational; depends on lcp_pkg.
`default_nettype none
module lcp_step (
    input  wire logic [7:0]         rx_byte,
    input  wire lcp_pkg::lcp_state_t st,
    output lcp_pkg::lcp_state_t     st_next,
    output lcp_pkg::lcp_result_t    res
);
    import lcp_pkg::*;

    logic             is_term;
    logic             is_digit;
    logic             is_ws;
    logic [LEN_W-1:0] p;
    logic [LEN_W-1:0] eff_len;
    logic [PROD_W-1:0] prod;
    logic [NUM_W-1:0]  num_acc;
    lcp_state_t       ns;
    rsp_code_t        code;
    logic             rvalid;

    assign is_term  = (rx_byte == CH_LF) || (rx_byte == CH_CR);
    assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign is_ws    = (rx_byte == CH_SPACE) || (rx_byte == CH_TAB) ||
                      (rx_byte == CH_VT) || (rx_byte == CH_FF);
    assign p        = st.content_len;
    assign eff_len  = st.content_len - st.space_run;

    // value*10 + digit, saturating
    assign prod    = PROD_W'({st.num_val, 3'b000}) + PROD_W'({st.num_val, 1'b0})
                   + PROD_W'(rx_byte[3:0]);
    assign num_acc = (prod > PROD_W'(NUMBER_CAP)) ? NUMBER_CAP : prod[NUM_W-1:0];

    always_comb begin
        ns     = st;
        rvalid = 1'b0;
        code   = RSP_UNKNOWN;

        if (is_term) begin
            if (st.line_len != '0) begin
                rvalid = 1'b1;
                if (st.kw_cand[KW_START] && eff_len == LEN_START) begin
                    ns.running = 1'b1;
                    code       = RSP_STARTED;
                end else if (st.kw_cand[KW_STOP] && eff_len == LEN_STOP) begin
                    ns.running = 1'b0;
                    code       = RSP_STOPPED;
                end else if (st.kw_cand[KW_STATUS] && eff_len == LEN_STATUS) begin
                    code = RSP_STATUS;
                end else if (st.kw_cand[KW_PREFIX] && st.content_len >= LEN_PREFIX) begin
                    if (st.num_neg && st.num_val != '0) begin
                        code = RSP_INVALID;
                    end else if (st.num_val >= TIME_MIN && st.num_val <= TIME_MAX) begin
                        ns.stored_time = st.num_val[TIME_W-1:0];
                        code           = RSP_TIME_SET;
                    end else begin
                        code = RSP_INVALID;
                    end
                end
                ns.line_len    = STATE_RESET.line_len;
                ns.content_len = STATE_RESET.content_len;
                ns.kw_cand     = STATE_RESET.kw_cand;
                ns.space_run   = STATE_RESET.space_run;
                ns.nul_seen    = STATE_RESET.nul_seen;
                ns.num_phase   = STATE_RESET.num_phase;
                ns.num_neg     = STATE_RESET.num_neg;
                ns.num_val     = STATE_RESET.num_val;
            end
        end else if (st.line_len >= LEN_LAST) begin
            rvalid         = 1'b1;
            code           = RSP_TOO_LONG;
            ns.line_len    = STATE_RESET.line_len;
            ns.content_len = STATE_RESET.content_len;
            ns.kw_cand     = STATE_RESET.kw_cand;
            ns.space_run   = STATE_RESET.space_run;
            ns.nul_seen    = STATE_RESET.nul_seen;
            ns.num_phase   = STATE_RESET.num_phase;
            ns.num_neg     = STATE_RESET.num_neg;
            ns.num_val     = STATE_RESET.num_val;
        end else begin
            ns.line_len = st.line_len + LEN_W'(1);
            if (!st.nul_seen) begin
                if (rx_byte == CH_NUL) begin
                    ns.nul_seen = 1'b1;
                end else begin
                    ns.content_len = st.content_len + LEN_W'(1);
                    if (rx_byte == CH_SPACE) begin
                        ns.space_run = st.space_run + LEN_W'(1);
                    end else begin
                        if (st.space_run != '0) begin
                            ns.kw_cand[KW_START]  = 1'b0;
                            ns.kw_cand[KW_STOP]   = 1'b0;
                            ns.kw_cand[KW_STATUS] = 1'b0;
                        end
                        ns.space_run = '0;
                        if (start_char(p) != rx_byte) begin
                            ns.kw_cand[KW_START] = 1'b0;
                        end
                        if (stop_char(p) != rx_byte) begin
                            ns.kw_cand[KW_STOP] = 1'b0;
                        end
                        if (status_char(p) != rx_byte) begin
                            ns.kw_cand[KW_STATUS] = 1'b0;
                        end
                    end
                    if (p < LEN_PREFIX) begin
                        if (prefix_char(p) != rx_byte) begin
                            ns.kw_cand[KW_PREFIX] = 1'b0;
                        end
                    end else if (st.kw_cand[KW_PREFIX]) begin
                        case (st.num_phase)
                            NUM_LEAD: begin
                                if (is_ws) begin
                                    ns.num_phase = NUM_LEAD;
                                end else if (rx_byte == CH_PLUS || rx_byte == CH_MINUS) begin
                                    ns.num_neg   = (rx_byte == CH_MINUS);
                                    ns.num_phase = NUM_DIGITS;
                                end else if (is_digit) begin
                                    ns.num_phase = NUM_DIGITS;
                                    ns.num_val   = num_acc;
                                end else begin
                                    ns.num_phase = NUM_DONE;
                                end
                            end
                            NUM_DIGITS: begin
                                if (is_digit) begin
                                    ns.num_val = num_acc;
                                end else begin
                                    ns.num_phase = NUM_DONE;
                                end
                            end
                            default: begin
                                ns.num_phase = st.num_phase;
                            end
                        endcase
                    end
                end
            end
        end
    end

    assign st_next     = ns;
    assign res.valid   = rvalid;
    assign res.code    = code;
    assign res.running = ns.running;
    assign res.itime   = ns.stored_time;

endmodule
`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for line_command_parser: streams command lines byte by byte
// and compares every response against a behavioral parser model kept in this file.
// Depends on lcp_pkg and the line_command_parser RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lcp_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_BYTES  = 80;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_LINES    = 10;

    localparam string TIME_CMD = {"SET_INT", "_TIME:"};

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    typedef struct {
        rsp_code_t         code;
        logic              run;
        logic [TIME_W-1:0] itime;
    } rsp_t;

    rsp_t       expected_rsp_q[$];
    logic [7:0] line_bytes[$];

    // parser model state
    string      kw_text[4] = '{"START", "STOP", "STATUS", TIME_CMD};
    int         line_len;
    int         text_len;
    int         space_run;
    int         num_val;
    logic [3:0] cand;
    bit         nul_hit;
    bit         num_neg;
    bit         run_flag;
    num_phase_t num_phase;
    int         stored_time;

    int error_count  = 0;
    int cycle_count  = 0;
    int bytes_sent   = 0;
    int stall_cycles = 0;
    int hold_len     = 0;
    int code_seen[7] = '{default: 0};
    bit idle_on      = 1'b1;

    line_command_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (s_tvalid && !s_tready) stall_cycles++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses pending",
                     cycle_count, expected_rsp_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[cycle %0d] mismatch: %s", cycle_count, what);
    endtask

    // ---------------- parser model ----------------

    function automatic void clear_line();
        line_len  = 0;
        text_len  = 0;
        cand      = 4'hF;
        space_run = 0;
        nul_hit   = 1'b0;
        num_phase = NUM_LEAD;
        num_neg   = 1'b0;
        num_val   = 0;
    endfunction

    function automatic void feed_number(input logic [7:0] b);
        bit digit;
        digit = (b >= CH_ZERO && b <= CH_NINE);
        if (num_phase == NUM_LEAD) begin
            if (b == CH_SPACE || b == CH_TAB || b == CH_VT || b == CH_FF) return;
            if (b == CH_PLUS || b == CH_MINUS) begin
                num_neg   = (b == CH_MINUS);
                num_phase = NUM_DIGITS;
                return;
            end
            if (!digit) begin
                num_phase = NUM_DONE;
                return;
            end
            num_phase = NUM_DIGITS;
        end else if (num_phase != NUM_DIGITS) begin
            return;
        end
        if (!digit) begin
            num_phase = NUM_DONE;
            return;
        end
        num_val = num_val * 10 + int'(b - CH_ZERO);
        if (num_val > int'(NUMBER_CAP)) num_val = int'(NUMBER_CAP);
    endfunction

    function automatic rsp_code_t finish_line();
        int eff;
        eff = text_len - space_run;
        if (cand[KW_START] && eff == kw_text[0].len()) begin
            run_flag = 1'b1;
            return RSP_STARTED;
        end
        if (cand[KW_STOP] && eff == kw_text[1].len()) begin
            run_flag = 1'b0;
            return RSP_STOPPED;
        end
        if (cand[KW_STATUS] && eff == kw_text[2].len()) return RSP_STATUS;
        if (cand[KW_PREFIX] && text_len >= kw_text[3].len()) begin
            if (num_neg && num_val != 0) return RSP_INVALID;
            if (num_val >= int'(TIME_MIN) && num_val <= int'(TIME_MAX)) begin
                stored_time = num_val;
                return RSP_TIME_SET;
            end
            return RSP_INVALID;
        end
        return RSP_UNKNOWN;
    endfunction

    function automatic void predict_byte(input logic [7:0] b);
        rsp_code_t code;
        rsp_t      r;
        int        p;
        if (b == CH_LF || b == CH_CR) begin
            if (line_len == 0) return;
            code = finish_line();
            clear_line();
        end else if (line_len >= LINE_CAPACITY - 1) begin
            clear_line();
            code = RSP_TOO_LONG;
        end else begin
            line_len++;
            if (nul_hit) return;
            if (b == CH_NUL) begin
                nul_hit = 1'b1;
                return;
            end
            p = text_len;
            text_len++;
            if (b == CH_SPACE) begin
                space_run++;
            end else begin
                if (space_run != 0) cand &= 4'b1000;
                space_run = 0;
                for (int k = 0; k < 3; k++) begin
                    if (p >= kw_text[k].len() || kw_text[k][p] != b) cand[k] = 1'b0;
                end
            end
            if (p < kw_text[3].len()) begin
                if (kw_text[3][p] != b) cand[KW_PREFIX] = 1'b0;
            end else if (cand[KW_PREFIX]) begin
                feed_number(b);
            end
            return;
        end
        r.code  = code;
        r.run   = run_flag;
        r.itime = TIME_W'(stored_time);
        expected_rsp_q.push_back(r);
    endfunction

    // ---------------- response checker ----------------

    always @(posedge aclk) begin : check_rsp
        rsp_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_rsp_q.size() == 0) begin
                report_mismatch($sformatf("response %h with none pending", m_tdata));
            end else begin
                want = expected_rsp_q.pop_front();
                code_seen[want.code]++;
                if (m_tdata[2:0] !== want.code)
                    report_mismatch($sformatf("code %0d, want %s",
                                              m_tdata[2:0], want.code.name()));
                if (m_tdata[3] !== want.run)
                    report_mismatch($sformatf("running %b, want %b", m_tdata[3], want.run));
                if (m_tdata[20:4] !== want.itime)
                    report_mismatch($sformatf("integration time %0d, want %0d",
                                              m_tdata[20:4], want.itime));
                if (m_tdata[23:21] !== 3'b000)
                    report_mismatch($sformatf("pad bits %b", m_tdata[23:21]));
            end
        end
    end

    // ---------------- receiver ----------------

    initial begin : receiver
        int stall;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (hold_len > 0) begin
                stall    = hold_len;
                hold_len = 0;
            end else begin
                stall = idle_on ? $urandom_range(0, 10) : 0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    // ---------------- sender ----------------

    // entered and left at a falling edge; tvalid stays high for a back-to-back item
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        predict_byte(b);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_rsp_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [7:0] rand_text_byte();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == CH_LF || c == CH_CR) c = c ^ 8'h40;
        return c;
    endfunction

    function automatic logic [7:0] pick_ws();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_VT;
            default: return CH_FF;
        endcase
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
    endfunction

    // one random line into line_bytes, mostly well formed
    task automatic build_line();
        int limit_vals[7] = '{0, 9, 10, 11, 99999, 100000, 100001};
        int v;
        int pos;
        int k;
        line_bytes.delete();
        case ($urandom_range(0, 9))
            0, 1: begin
                push_text(kw_text[$urandom_range(0, 2)]);
                repeat ($urandom_range(0, 3)) line_bytes.push_back(CH_SPACE);
            end
            2, 3, 4, 5: begin
                push_text(kw_text[3]);
                repeat ($urandom_range(0, 2)) line_bytes.push_back(pick_ws());
                case ($urandom_range(0, 3))
                    0:       line_bytes.push_back(CH_PLUS);
                    1:       line_bytes.push_back(CH_MINUS);
                    default: ;
                endcase
                case ($urandom_range(0, 4))
                    1:       v = limit_vals[$urandom_range(0, 6)];
                    2:       v = $urandom_range(0, 999999999);
                    3:       v = $urandom_range(0, 200);
                    default: v = $urandom_range(10, 100000);
                endcase
                if ($urandom_range(0, 5) == 0) line_bytes.push_back(CH_ZERO);
                if ($urandom_range(0, 9) != 0) push_text($sformatf("%0d", v));
                case ($urandom_range(0, 5))
                    0:       line_bytes.push_back(rand_text_byte());
                    1:       repeat ($urandom_range(1, 3)) line_bytes.push_back(CH_SPACE);
                    default: ;
                endcase
            end
            6: begin
                repeat ($urandom_range(1, 20)) line_bytes.push_back(8'($urandom_range(0, 255)));
            end
            7: begin
                repeat ($urandom_range(55, 70)) line_bytes.push_back(rand_text_byte());
            end
            8: begin
                k = $urandom_range(0, 3);
                push_text(kw_text[k]);
                pos = $urandom_range(0, line_bytes.size() - 1);
                case ($urandom_range(0, 2))
                    0:       line_bytes[pos] = rand_text_byte();
                    1:       line_bytes[pos] = CH_NUL;
                    default: line_bytes[pos] = line_bytes[pos] | 8'h20;
                endcase
                if (k == 3) push_text("50");
            end
            default: ;
        endcase
        line_bytes.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
    endtask

    // ---------------- tests ----------------

    task automatic test_keywords();
        send_text("START\n");
        send_text("STATUS\r");
        send_text("STOP  \n");
        send_text("\n\r");
        send_text("START \r");
        send_text("STAR\n");
        send_text(" STOP\n");
        send_text("STA RT\n");
        send_text("STATUSX\n");
        send_text({TIME_CMD.substr(0, TIME_CMD.len() - 2), "\n"});
        wait_drained();
    endtask

    task automatic test_set_time();
        send_text({TIME_CMD, "10\n"});
        send_text({TIME_CMD, "100000\r"});
        send_text({TIME_CMD, "9\n"});
        send_text({TIME_CMD, "100001\n"});
        send_text({TIME_CMD, "-0\n"});
        send_text({TIME_CMD, "-50\n"});
        send_text({TIME_CMD, " \t"});
        send_byte(CH_VT);
        send_byte(CH_FF);
        send_text("+0042x9\n");
        send_text({TIME_CMD, "99999999999\n"});
        send_text({TIME_CMD, "\n"});
        send_text({TIME_CMD, "+\n"});
        send_text({TIME_CMD, "77  \n"});
        send_text({TIME_CMD, "12 34\n"});
        wait_drained();
    endtask

    task automatic test_nul_and_overflow();
        send_byte(CH_NUL);
        send_text("STOP\n");
        send_text("START");
        send_byte(CH_NUL);
        send_text("xyz\n");
        // full-length line still completes
        send_text("STOP");
        repeat (LINE_CAPACITY - 5) send_byte(CH_SPACE);
        send_text("\n");
        // one byte past capacity
        repeat (LINE_CAPACITY) send_byte(8'hFF);
        send_text("STATUS\r");
        send_byte(CH_NUL);
        repeat (LINE_CAPACITY) send_byte(8'h61);
        send_text("\n");
        wait_drained();
    endtask

    task automatic test_backpressure();
        idle_on  = 1'b0;
        hold_len = HOLD_CYCLES;
        repeat (HOLD_LINES) send_text("STATUS\n");
        idle_on = 1'b1;
        wait_drained();
    endtask

    task automatic test_random();
        int goal;
        goal = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < goal) begin
            build_line();
            idle_on = ($urandom_range(0, 7) != 0);
            foreach (line_bytes[i]) send_byte(line_bytes[i]);
            if ($urandom_range(0, 39) == 0) wait_drained();
        end
        idle_on = 1'b1;
        wait_drained();
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        clear_line();
        run_flag    = 1'b0;
        stored_time = int'(TIME_DEFAULT);
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_keywords();
        test_set_time();
        test_nul_and_overflow();
        test_backpressure();
        test_random();

        $display("sent %0d bytes; responses: %0d started, %0d stopped, %0d status, %0d stored",
                 bytes_sent, code_seen[RSP_STARTED], code_seen[RSP_STOPPED],
                 code_seen[RSP_STATUS], code_seen[RSP_TIME_SET]);
        $display("%0d invalid, %0d unknown, %0d too long; input held off %0d cycles",
                 code_seen[RSP_INVALID], code_seen[RSP_UNKNOWN], code_seen[RSP_TOO_LONG],
                 stall_cycles);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* line_command_parser.f */
src/lcp_pkg.sv
src/lcp_step.sv
src/line_command_parser.sv
bench/tb_top.sv
